/* rtl/core/bccd_pkg.sv */
`timescale 1ns / 1ps

package bccd_pkg;

  // Field widths fixed by the item format
  localparam int SAMPLE_W   = 16;
  localparam int THR_W      = 16;
  localparam int CNT_W      = 7;
  localparam int PCT_W      = 7;
  localparam int OP_W       = 2;

  // Defaults for the top-level parameters
  localparam int GRID_DIM_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // Frame totals
  localparam logic [CNT_W-1:0] COUNT_MAX     = 7'd127;
  localparam int               PERCENT_SCALE = 100;

  typedef logic [OP_W-1:0] op_t;

  // Operation codes
  localparam op_t OP_POLL    = 2'd0;
  localparam op_t OP_CAPTURE = 2'd1;
  localparam op_t OP_ACCEPT  = 2'd2;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_DETECT_MODE     = 2'd0;
  localparam cfg_addr_t CFG_BOX_THRESHOLD   = 2'd1;
  localparam cfg_addr_t CFG_CLASS_THRESHOLD = 2'd2;

endpackage

/* rtl/core/box_centre_change_detector.sv */
`timescale 1ns / 1ps

// Channel | Dir | Fields (lowest bit up)
// --------+-----+------------------------------------------------------------
// in_     | in  | tuser: operation; tdata: box_row, box_col, sample
// out_    | out | tlast: frame_done; tdata: out_row, out_col, rescan_box,
//         |     |   difference, max_difference, count_over, any_changed,
//         |     |   change_percent
// cfg_    | in  | cfg_we, cfg_addr (register index), cfg_wdata
//
// One item per cycle sustained while the output is not stalled.
// The read stage reads both box stores (registered read); the result stage does
// compare, store update and frame totals into the output register.
// A write from the result stage to the box just being read is forwarded.
// Synchronous active-low reset clears control state and the per-box valid
// bits, so both stores read as zero afterwards with no clearing pass.
// A stalled output holds the result; the read stage holds its item and
// in_tready drops only when both stages are full.
module box_centre_change_detector #(
  parameter int GRID_DIM    = bccd_pkg::GRID_DIM_DEF,
  parameter int SAMPLE_BITS = bccd_pkg::SAMPLE_BITS_DEF,
  localparam int COORD_W    = $clog2(GRID_DIM),
  localparam int IN_USED_W  = 2 * COORD_W + bccd_pkg::SAMPLE_W,
  localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8,
  localparam int OUT_USED_W = 2 * COORD_W + 2 + 2 * bccd_pkg::SAMPLE_W
                              + bccd_pkg::CNT_W + bccd_pkg::PCT_W,
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input item
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // box_row, box_col, sample, zero pad
  input  logic [IN_DATA_W-1:0]        in_tdata,
  // operation
  input  logic [bccd_pkg::OP_W-1:0]   in_tuser,
  // result item
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_row, out_col, rescan_box, difference, max_difference, count_over,
  // any_changed, change_percent, zero pad
  output logic [OUT_DATA_W-1:0]       out_tdata,
  // frame_done
  output logic                        out_tlast,
  // configuration
  input  logic                        cfg_we,
  input  logic [bccd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bccd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int Cells      = GRID_DIM * GRID_DIM;
  localparam int CELL_W     = $clog2(Cells);
  localparam int SW         = SAMPLE_BITS;
  localparam int CountLevels = 1 << bccd_pkg::CNT_W;

  // Configuration registers
  logic                        mode_r;
  logic [bccd_pkg::THR_W-1:0]  box_thr_r;
  logic [bccd_pkg::THR_W-1:0]  class_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      box_thr_r   <= '0;
      class_thr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bccd_pkg::CFG_DETECT_MODE:     mode_r      <= cfg_wdata[0];
        bccd_pkg::CFG_BOX_THRESHOLD:   box_thr_r   <= cfg_wdata[bccd_pkg::THR_W-1:0];
        bccd_pkg::CFG_CLASS_THRESHOLD: class_thr_r <= cfg_wdata[bccd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input unpacking
  bccd_pkg::op_t        in_op;
  logic [COORD_W-1:0]   in_row;
  logic [COORD_W-1:0]   in_col;
  logic [SW-1:0]        in_smp;
  logic                 in_grid;
  logic [CELL_W-1:0]    in_cell;
  logic                 in_fire;

  assign in_op   = in_tuser;
  assign in_row  = in_tdata[COORD_W-1:0];
  assign in_col  = in_tdata[2*COORD_W-1:COORD_W];
  assign in_smp  = in_tdata[2*COORD_W +: SW];
  assign in_grid = (int'(in_row) < GRID_DIM) && (int'(in_col) < GRID_DIM);
  assign in_cell = in_grid ? CELL_W'(int'(in_row) * GRID_DIM + int'(in_col)) : '0;
  assign in_fire = in_tvalid && in_tready;

  // Read stage registers
  logic                 s1_v_r;
  bccd_pkg::op_t        s1_op_r;
  logic [COORD_W-1:0]   s1_row_r;
  logic [COORD_W-1:0]   s1_col_r;
  logic [SW-1:0]        s1_smp_r;
  logic                 s1_grid_r;
  logic [CELL_W-1:0]    s1_cell_r;
  logic                 fire;
  logic                 out_v_r;

  assign fire      = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_op;
      s1_row_r  <= in_row;
      s1_col_r  <= in_col;
      s1_smp_r  <= in_smp;
      s1_grid_r <= in_grid;
      s1_cell_r <= in_cell;
    end
  end

  // Box stores: one write and one registered read each
  logic [SW-1:0]        bg_mem  [Cells];
  logic [SW-1:0]        lat_mem [Cells];
  logic [Cells-1:0]     bg_vld_r;
  logic [Cells-1:0]     lat_vld_r;
  logic                 bg_we;
  logic [SW-1:0]        bg_wd;
  logic                 lat_we;
  logic [SW-1:0]        bg_rd_r;
  logic [SW-1:0]        lat_rd_r;

  always_ff @(posedge clk) begin
    if (bg_we) begin
      bg_mem[s1_cell_r] <= bg_wd;
    end
    if (in_fire) begin
      bg_rd_r <= bg_mem[in_cell];
    end
  end

  always_ff @(posedge clk) begin
    if (lat_we) begin
      lat_mem[s1_cell_r] <= s1_smp_r;
    end
    if (in_fire) begin
      lat_rd_r <= lat_mem[in_cell];
    end
  end

  // Valid bits: an unwritten box reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_vld_r  <= '0;
      lat_vld_r <= '0;
    end else begin
      if (bg_we)  bg_vld_r[s1_cell_r]  <= 1'b1;
      if (lat_we) lat_vld_r[s1_cell_r] <= 1'b1;
    end
  end

  // Read flags and forwarding of a write to the box being read
  logic                 bg_ok_r;
  logic                 lat_ok_r;
  logic                 bg_byp_r;
  logic                 lat_byp_r;
  logic [SW-1:0]        bg_byp_d_r;
  logic [SW-1:0]        lat_byp_d_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      bg_ok_r     <= bg_vld_r[in_cell];
      lat_ok_r    <= lat_vld_r[in_cell];
      bg_byp_r    <= bg_we && (s1_cell_r == in_cell);
      lat_byp_r   <= lat_we && (s1_cell_r == in_cell);
      bg_byp_d_r  <= bg_wd;
      lat_byp_d_r <= s1_smp_r;
    end
  end

  logic [SW-1:0] bg_val;
  logic [SW-1:0] lat_val;

  assign bg_val  = bg_byp_r  ? bg_byp_d_r  : (bg_ok_r  ? bg_rd_r  : '0);
  assign lat_val = lat_byp_r ? lat_byp_d_r : (lat_ok_r ? lat_rd_r : '0);

  // Compare and update
  logic                        is_poll;
  logic                        is_last;
  logic [SW-1:0]               diff;
  logic [bccd_pkg::THR_W-1:0]  diff_ext;
  logic                        over;
  logic [SW-1:0]               run_max_r;
  logic [SW-1:0]               run_max_nxt;
  logic [bccd_pkg::CNT_W-1:0]  run_cnt_r;
  logic [bccd_pkg::CNT_W-1:0]  run_cnt_nxt;

  assign is_poll  = s1_grid_r && (s1_op_r == bccd_pkg::OP_POLL);
  assign is_last  = (s1_row_r == COORD_W'(GRID_DIM - 1))
                    && (s1_col_r == COORD_W'(GRID_DIM - 1));
  assign diff     = (s1_smp_r >= bg_val) ? (s1_smp_r - bg_val) : (bg_val - s1_smp_r);
  assign diff_ext = bccd_pkg::THR_W'(diff);
  assign over     = mode_r ? (diff_ext > class_thr_r) : (diff_ext > box_thr_r);

  assign run_max_nxt = (diff > run_max_r) ? diff : run_max_r;
  assign run_cnt_nxt = (over && (run_cnt_r != bccd_pkg::COUNT_MAX))
                       ? run_cnt_r + 1'b1 : run_cnt_r;

  // Store writes
  always_comb begin
    bg_we  = 1'b0;
    bg_wd  = s1_smp_r;
    lat_we = fire && is_poll;
    if (fire && s1_grid_r) begin
      unique case (s1_op_r)
        bccd_pkg::OP_CAPTURE: bg_we = 1'b1;
        bccd_pkg::OP_ACCEPT: begin
          bg_we = 1'b1;
          bg_wd = lat_val;
        end
        bccd_pkg::OP_POLL: bg_we = !mode_r && over;
        default: bg_we = 1'b0;
      endcase
    end
  end

  // Frame totals, cleared once the closing poll has reported them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_max_r <= '0;
      run_cnt_r <= '0;
    end else if (fire && is_poll) begin
      if (is_last) begin
        run_max_r <= '0;
        run_cnt_r <= '0;
      end else begin
        run_max_r <= run_max_nxt;
        run_cnt_r <= run_cnt_nxt;
      end
    end
  end

  // Percent table: count times 100 over the number of boxes, capped
  logic [bccd_pkg::PCT_W-1:0] pct_tab [CountLevels];

  for (genvar gi = 0; gi < CountLevels; gi++) begin : g_pct
    localparam int PctRaw = (gi * bccd_pkg::PERCENT_SCALE) / Cells;
    assign pct_tab[gi] = (PctRaw > bccd_pkg::PERCENT_SCALE)
                         ? bccd_pkg::PCT_W'(bccd_pkg::PERCENT_SCALE)
                         : bccd_pkg::PCT_W'(PctRaw);
  end

  // Result register
  logic [COORD_W-1:0]           out_row_r;
  logic [COORD_W-1:0]           out_col_r;
  logic                         out_rescan_r;
  logic [bccd_pkg::SAMPLE_W-1:0] out_diff_r;
  logic                         out_done_r;
  logic [bccd_pkg::SAMPLE_W-1:0] out_max_r;
  logic [bccd_pkg::CNT_W-1:0]   out_cnt_r;
  logic                         out_any_r;
  logic [bccd_pkg::PCT_W-1:0]   out_pct_r;
  logic                         frame_close;

  assign frame_close = is_poll && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_row_r    <= s1_row_r;
      out_col_r    <= s1_col_r;
      out_rescan_r <= is_poll && !mode_r && over;
      out_diff_r   <= is_poll ? bccd_pkg::SAMPLE_W'(diff) : '0;
      out_done_r   <= frame_close;
      out_max_r    <= frame_close ? bccd_pkg::SAMPLE_W'(run_max_nxt) : '0;
      out_cnt_r    <= frame_close ? run_cnt_nxt : '0;
      out_any_r    <= frame_close && (run_cnt_nxt != '0);
      out_pct_r    <= frame_close ? pct_tab[run_cnt_nxt] : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_done_r;
  assign out_tdata  = OUT_DATA_W'({out_pct_r, out_any_r, out_cnt_r, out_max_r,
                                   out_diff_r, out_rescan_r, out_col_r, out_row_r});

  // Checks
  a_totals_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && frame_close |=> (run_max_r == '0) && (run_cnt_r == '0))
    else $error("frame totals not cleared after closing poll");

  a_totals_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_done_r |-> (out_max_r == '0) && (out_cnt_r == '0)
                              && !out_any_r && (out_pct_r == '0))
    else $error("frame totals on a result that does not close a frame");

  a_any_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_done_r |-> (out_any_r == (out_cnt_r != '0)))
    else $error("any_changed disagrees with count_over");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(fire))
    else $error("result appeared without an item leaving the read stage");

endmodule

/* sim/bccd_checker.sv */
`timescale 1ns / 1ps

module bccd_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  // box_row, box_col, sample, zero pad
  input  logic [23:0]                         in_tdata,
  // operation
  input  logic [bccd_pkg::OP_W-1:0]           in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  // out_row, out_col, rescan_box, difference, max_difference, count_over,
  // any_changed, change_percent, zero pad
  input  logic [55:0]                         out_tdata,
  // frame_done
  input  logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [bccd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bccd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                  mismatches,
  output int                                  pending,
  output int                                  results_seen,
  output int                                  frames_seen
);

  localparam int GRID  = bccd_pkg::GRID_DIM_DEF;
  localparam int CELLS = GRID * GRID;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic        rescan;
    logic [15:0] diff;
    logic        done;
    logic [15:0] max_diff;
    logic [6:0]  count;
    logic        any;
    logic [6:0]  pct;
  } box_result_t;

  // Shadow of the block state and registers
  logic        mode_cls;
  logic [15:0] box_thr;
  logic [15:0] cls_thr;
  logic [15:0] bg_store     [CELLS];
  logic [15:0] latest_store [CELLS];
  logic [15:0] frame_max;
  logic [6:0]  frame_count;

  box_result_t expected_q[$];
  int          errs;
  int          n_results;
  int          n_frames;

  task automatic clear_shadow();
    mode_cls    = 1'b0;
    box_thr     = '0;
    cls_thr     = '0;
    frame_max   = '0;
    frame_count = '0;
    for (int i = 0; i < CELLS; i++) begin
      bg_store[i]     = '0;
      latest_store[i] = '0;
    end
  endtask

  // Works out the result of one item and updates the shadow state
  function automatic box_result_t predict_box(bccd_pkg::op_t op, logic [2:0] row,
                                              logic [2:0] col, logic [15:0] smp);
    box_result_t r;
    int          box_idx;
    logic [15:0] bg;
    logic [15:0] diff;
    logic        over;
    int          pct;
    r       = '0;
    r.row   = row;
    r.col   = col;
    box_idx = int'(row) * GRID + int'(col);
    case (op)
      bccd_pkg::OP_CAPTURE: bg_store[box_idx] = smp;
      bccd_pkg::OP_ACCEPT:  bg_store[box_idx] = latest_store[box_idx];
      bccd_pkg::OP_POLL: begin
        bg   = bg_store[box_idx];
        diff = (smp >= bg) ? smp - bg : bg - smp;
        latest_store[box_idx] = smp;
        if (diff > frame_max) frame_max = diff;
        if (!mode_cls) begin
          over = diff > box_thr;
          if (over) begin
            r.rescan          = 1'b1;
            bg_store[box_idx] = smp;
          end
        end else begin
          over = diff > cls_thr;
        end
        if (over && frame_count != bccd_pkg::COUNT_MAX) frame_count = frame_count + 1'b1;
        r.diff = diff;
        // closing cell: report totals, then start a fresh frame
        if (row == GRID - 1 && col == GRID - 1) begin
          pct = int'(frame_count) * bccd_pkg::PERCENT_SCALE / CELLS;
          if (pct > bccd_pkg::PERCENT_SCALE) pct = bccd_pkg::PERCENT_SCALE;
          r.done      = 1'b1;
          r.max_diff  = frame_max;
          r.count     = frame_count;
          r.any       = frame_count != 0;
          r.pct       = pct[6:0];
          frame_max   = '0;
          frame_count = '0;
        end
      end
      default: ;  // undefined code leaves everything alone
    endcase
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errs++;
    end
  endtask

  initial clear_shadow();

  always @(posedge clk) begin : watch
    box_result_t want;
    box_result_t got;
    if (!rst_n) begin
      clear_shadow();
      expected_q.delete();
    end else begin
      // result side first: an item accepted at this edge cannot be out yet
      if (out_tvalid && out_tready) begin
        got.row      = out_tdata[2:0];
        got.col      = out_tdata[5:3];
        got.rescan   = out_tdata[6];
        got.diff     = out_tdata[22:7];
        got.max_diff = out_tdata[38:23];
        got.count    = out_tdata[45:39];
        got.any      = out_tdata[46];
        got.pct      = out_tdata[53:47];
        got.done     = out_tlast;
        n_results++;
        if (got.done) n_frames++;
        if (expected_q.size() == 0) begin
          $display("%0t: result with no item pending, expected none, actual tdata %h",
                   $time, out_tdata);
          errs++;
        end else begin
          want = expected_q.pop_front();
          check_field("out_row", want.row, got.row);
          check_field("out_col", want.col, got.col);
          check_field("rescan_box", want.rescan, got.rescan);
          check_field("difference", want.diff, got.diff);
          check_field("frame_done", want.done, got.done);
          check_field("max_difference", want.max_diff, got.max_diff);
          check_field("count_over", want.count, got.count);
          check_field("any_changed", want.any, got.any);
          check_field("change_percent", want.pct, got.pct);
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(predict_box(in_tuser, in_tdata[2:0], in_tdata[5:3],
                                         in_tdata[21:6]));
      if (cfg_we) begin
        case (cfg_addr)
          bccd_pkg::CFG_DETECT_MODE:     mode_cls = cfg_wdata[0];
          bccd_pkg::CFG_BOX_THRESHOLD:   box_thr  = cfg_wdata;
          bccd_pkg::CFG_CLASS_THRESHOLD: cls_thr  = cfg_wdata;
          default: ;
        endcase
      end
    end
    mismatches   <= errs;
    pending      <= expected_q.size();
    results_seen <= n_results;
    frames_seen  <= n_frames;
  end

endmodule

/* sim/tb_box_centre_change_detector.sv */
`timescale 1ns / 1ps

module tb_box_centre_change_detector;

  localparam bccd_pkg::op_t OP_UNDEF = 2'd3;
  localparam int            GRID     = bccd_pkg::GRID_DIM_DEF;
  localparam int            N_PHASES = 6;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata  = '0;
  logic [bccd_pkg::OP_W-1:0] in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we    = 1'b0;
  logic [bccd_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [bccd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches;
  int pending;
  int results_seen;
  int frames_seen;

  logic idle_en    = 1'b1;
  int   stall_left = 0;
  int   items_sent = 0;

  // register settings per random phase; the last one's thresholds and span are drawn at random
  int unsigned ph_mode [N_PHASES] = '{0, 1, 0, 1, 0, 1};
  int unsigned ph_bthr [N_PHASES] = '{500, 0, 65535, 65535, 0, 0};
  int unsigned ph_cthr [N_PHASES] = '{0, 500, 65535, 0, 12345, 0};
  int unsigned ph_span [N_PHASES] = '{1000, 1000, 65535, 40, 8, 0};

  box_centre_change_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  bccd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .frames_seen  (frames_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure in short bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // one item, sometimes preceded by an idle gap
  task automatic send_item(bccd_pkg::op_t op, int row, int col, logic [15:0] smp);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, smp, col[2:0], row[2:0]};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // hold the input until every expected result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(int unsigned mode, int unsigned bthr, int unsigned cthr);
    cfg_we    <= 1'b1;
    cfg_addr  <= bccd_pkg::CFG_DETECT_MODE;
    cfg_wdata <= mode[15:0];
    @(posedge clk);
    cfg_addr  <= bccd_pkg::CFG_BOX_THRESHOLD;
    cfg_wdata <= bthr[15:0];
    @(posedge clk);
    cfg_addr  <= bccd_pkg::CFG_CLASS_THRESHOLD;
    cfg_wdata <= cthr[15:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample(int unsigned base, int unsigned span);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'(base + $urandom_range(0, span));
  endfunction

  // raster pass over the grid, mostly polls with the odd capture, accept or undefined code
  task automatic raster_frame(int unsigned base, int unsigned span);
    int            pick;
    bccd_pkg::op_t op;
    for (int c = 0; c < GRID * GRID; c++) begin
      pick = $urandom_range(0, 19);
      if (pick < 17)       op = bccd_pkg::OP_POLL;
      else if (pick == 17) op = bccd_pkg::OP_CAPTURE;
      else if (pick == 18) op = bccd_pkg::OP_ACCEPT;
      else                 op = OP_UNDEF;
      send_item(op, c / GRID, c % GRID, pick_sample(base, span));
    end
  endtask

  task automatic noise_burst(int n);
    bccd_pkg::op_t op;
    for (int i = 0; i < n; i++) begin
      op = bccd_pkg::op_t'($urandom_range(0, 3));
      send_item(op, $urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                16'($urandom));
    end
  endtask

  // many repeated polls before the close, to push the count into saturation
  task automatic saturating_frame(int unsigned base, int unsigned span);
    int c;
    for (int i = 0; i < 130; i++) begin
      c = $urandom_range(0, GRID * GRID - 2);
      send_item(bccd_pkg::OP_POLL, c / GRID, c % GRID, pick_sample(base, span));
    end
    send_item(bccd_pkg::OP_POLL, GRID - 1, GRID - 1, pick_sample(base, span));
  endtask

  initial begin
    int unsigned base;
    int unsigned bthr;
    int unsigned cthr;
    int unsigned span;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: box mode, strict threshold edge, capture, accept, bad code
    set_config(0, 100, 16'hFFFF);
    send_item(bccd_pkg::OP_POLL,    0, 0, 16'hFFFF);
    send_item(bccd_pkg::OP_POLL,    0, 0, 16'h0000);
    send_item(bccd_pkg::OP_CAPTURE, 1, 2, 16'h1234);
    send_item(bccd_pkg::OP_POLL,    1, 2, 16'h1298);
    send_item(bccd_pkg::OP_POLL,    1, 2, 16'h1299);
    send_item(bccd_pkg::OP_CAPTURE, 1, 2, 16'h0000);
    send_item(bccd_pkg::OP_ACCEPT,  1, 2, 16'hFFFF);
    send_item(bccd_pkg::OP_POLL,    1, 2, 16'h1299);
    send_item(OP_UNDEF,             2, 3, 16'hAAAA);
    send_item(bccd_pkg::OP_POLL,    2, 3, 16'h0000);
    send_item(bccd_pkg::OP_POLL,    7, 0, 16'h8000);
    send_item(bccd_pkg::OP_POLL,    0, 7, 16'h7FFF);
    send_item(bccd_pkg::OP_POLL,    7, 7, 16'h5555);
    send_item(bccd_pkg::OP_POLL,    7, 7, 16'h5555);
    drain();

    // directed: classification mode, zero threshold
    set_config(1, 0, 0);
    send_item(bccd_pkg::OP_POLL,    3, 4, 16'h0001);
    send_item(bccd_pkg::OP_POLL,    3, 4, 16'h0000);
    send_item(OP_UNDEF,             7, 7, 16'h3FFF);
    send_item(bccd_pkg::OP_POLL,    7, 7, 16'hFFFF);
    send_item(bccd_pkg::OP_CAPTURE, 7, 7, 16'hFFFF);
    send_item(bccd_pkg::OP_POLL,    7, 7, 16'hFFFF);
    drain();

    // random phases, each under its own register setting
    for (int p = 0; p < N_PHASES; p++) begin
      bthr = ph_bthr[p];
      cthr = ph_cthr[p];
      span = ph_span[p];
      if (p == N_PHASES - 1) begin
        idle_en = 1'b0;
        span    = $urandom_range(1, 4000);
        bthr    = $urandom_range(0, span);
        cthr    = $urandom_range(0, span);
      end
      set_config(ph_mode[p], bthr, cthr);
      base = $urandom_range(0, 65535 - span);
      raster_frame(base, span);
      noise_burst(16);
      if (p == 3) saturating_frame(base, span);
      drain();
    end

    $display("Sent %0d items over %0d register settings, polls, captures, accepts and bad codes",
             items_sent, N_PHASES + 2);
    $display("Checked %0d results, %0d of them frame closes incl. a saturated count",
             results_seen, frames_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
